// ----- hw/rtl/psalu_pkg.sv -----
// ----------------------------------------------------------------------------
// psalu_pkg
// Function codes, status codes and field widths shared by the packed SIMD ALU,
// its lane datapath and its port checker.
// ----------------------------------------------------------------------------
package psalu_pkg;

   localparam int unsigned OperandWidth = 128;
   localparam int unsigned OpcodeWidth  = 5;
   localparam int unsigned StatusWidth  = 2;

   // Function field of the instruction. Codes not listed here are reserved.
   typedef enum logic [OpcodeWidth-1:0] {
      OP_ABS_W   = 5'd1,
      OP_CEQ_W   = 5'd2,
      OP_MIN_W   = 5'd3,
      OP_SUBADD_H = 5'd4,
      OP_ABS_H   = 5'd5,
      OP_CEQ_H   = 5'd6,
      OP_MIN_H   = 5'd7,
      OP_CEQ_B   = 5'd10,
      OP_ADDUS_W = 5'd16,
      OP_SUBUS_W = 5'd17,
      OP_EXTUP_W = 5'd18,
      OP_ADDUS_H = 5'd20,
      OP_SUBUS_H = 5'd21,
      OP_EXTUP_H = 5'd22,
      OP_ADDUS_B = 5'd24,
      OP_SUBUS_B = 5'd25,
      OP_EXTUP_B = 5'd26,
      OP_FUNNEL  = 5'd27
   } opcode_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_DONE     = 2'd0,
      ST_RESERVED = 2'd1,
      ST_FUNNEL   = 2'd2
   } status_type;

endpackage

// ----- hw/rtl/packed_simd_alu_128.sv -----
// ----------------------------------------------------------------------------
// packed_simd_alu_128
// 128-bit packed multimedia ALU with an input register and a result register.
//
//   Channel | Direction | tdata                  | tuser
//   req     | in        | first[127:0], second   | opcode (5 bits)
//   rsp     | out       | result[127:0]          | status (2 bits)
//
// Each beat passes through the input register and then the result register,
// and its result shows on rsp once it sits in the result register.
// One beat is taken every cycle while the result side keeps draining.
// A stall on rsp backs up through both registers to req_tready.
// Reset clears both valid flags; the data registers are not reset.
// ----------------------------------------------------------------------------
module packed_simd_alu_128
   import psalu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // first_low, first_high, second_low, second_high
   input  logic [2*OperandWidth-1:0] req_tdata,
   // opcode
   input  logic [OpcodeWidth-1:0]  req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // result_low, result_high
   output logic [OperandWidth-1:0] rsp_tdata,
   // status
   output logic [StatusWidth-1:0]  rsp_tuser
);

   logic                    in_valid_ff, in_valid_in;
   logic [OpcodeWidth-1:0]  in_opcode_ff;
   logic [OperandWidth-1:0] in_first_ff, in_second_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [OperandWidth-1:0] out_result_ff;
   status_type              out_status_ff;

   logic                    out_ready;
   logic                    in_ready;
   logic [OperandWidth-1:0] alu_result;
   status_type              alu_status;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign in_ready   = !in_valid_ff || out_ready;
   assign req_tready = in_ready;

   assign in_valid_in  = in_ready ? req_tvalid : in_valid_ff;
   assign out_valid_in = out_ready ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_tvalid) begin
         in_opcode_ff <= req_tuser;
         in_first_ff  <= req_tdata[OperandWidth-1:0];
         in_second_ff <= req_tdata[2*OperandWidth-1:OperandWidth];
      end
      if (out_ready && in_valid_ff) begin
         out_result_ff <= alu_result;
         out_status_ff <= alu_status;
      end
   end

   psalu_lanes u_lanes (
      .opcode (in_opcode_ff),
      .first  (in_first_ff),
      .second (in_second_ff),
      .result (alu_result),
      .status (alu_status)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_result_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

// ----- hw/rtl/psalu_lanes.sv -----
// ----------------------------------------------------------------------------
// psalu_lanes
// Combinational lane datapath: computes every word, halfword and byte
// operation side by side and selects one result by the function code.
// ----------------------------------------------------------------------------
module psalu_lanes
   import psalu_pkg::*;
(
   input  logic [OpcodeWidth-1:0]  opcode,
   input  logic [OperandWidth-1:0] first,
   input  logic [OperandWidth-1:0] second,
   output logic [OperandWidth-1:0] result,
   output status_type              status
);

   logic [OperandWidth-1:0] abs_w, eq_w, min_w, addus_w, subus_w, ilv_w;
   logic [OperandWidth-1:0] abs_h, eq_h, min_h, addus_h, subus_h, ilv_h, mix_h;
   logic [OperandWidth-1:0] eq_b, addus_b, subus_b, ilv_b;

   // Word lanes.
   always_comb begin
      logic [31:0] aw, bw;
      logic [32:0] sw;
      abs_w   = '0;
      eq_w    = '0;
      min_w   = '0;
      addus_w = '0;
      subus_w = '0;
      ilv_w   = '0;
      for (int i = 0; i < 4; i++) begin
         aw = first[i*32 +: 32];
         bw = second[i*32 +: 32];
         sw = {1'b0, aw} + {1'b0, bw};
         // The most negative value saturates to the most positive one.
         if (!bw[31]) begin
            abs_w[i*32 +: 32] = bw;
         end else if (bw == {1'b1, 31'd0}) begin
            abs_w[i*32 +: 32] = {1'b0, {31{1'b1}}};
         end else begin
            abs_w[i*32 +: 32] = ~bw + 32'd1;
         end
         eq_w[i*32 +: 32]    = {32{aw == bw}};
         min_w[i*32 +: 32]   = ($signed(aw) <= $signed(bw)) ? aw : bw;
         addus_w[i*32 +: 32] = sw[32] ? {32{1'b1}} : sw[31:0];
         subus_w[i*32 +: 32] = (aw >= bw) ? (aw - bw) : 32'd0;
      end
      for (int k = 0; k < 2; k++) begin
         ilv_w[(2*k)*32 +: 32]   = second[(2+k)*32 +: 32];
         ilv_w[(2*k+1)*32 +: 32] = first[(2+k)*32 +: 32];
      end
   end

   // Halfword lanes.
   always_comb begin
      logic [15:0] ah, bh;
      logic [16:0] sh;
      abs_h   = '0;
      eq_h    = '0;
      min_h   = '0;
      addus_h = '0;
      subus_h = '0;
      ilv_h   = '0;
      mix_h   = '0;
      for (int i = 0; i < 8; i++) begin
         ah = first[i*16 +: 16];
         bh = second[i*16 +: 16];
         sh = {1'b0, ah} + {1'b0, bh};
         if (!bh[15]) begin
            abs_h[i*16 +: 16] = bh;
         end else if (bh == {1'b1, 15'd0}) begin
            abs_h[i*16 +: 16] = {1'b0, {15{1'b1}}};
         end else begin
            abs_h[i*16 +: 16] = ~bh + 16'd1;
         end
         eq_h[i*16 +: 16]    = {16{ah == bh}};
         min_h[i*16 +: 16]   = ($signed(ah) <= $signed(bh)) ? ah : bh;
         addus_h[i*16 +: 16] = sh[16] ? {16{1'b1}} : sh[15:0];
         subus_h[i*16 +: 16] = (ah >= bh) ? (ah - bh) : 16'd0;
         // Low four lanes subtract, high four lanes add, both wrapping.
         mix_h[i*16 +: 16]   = (i < 4) ? (ah - bh) : sh[15:0];
      end
      for (int k = 0; k < 4; k++) begin
         ilv_h[(2*k)*16 +: 16]   = second[(4+k)*16 +: 16];
         ilv_h[(2*k+1)*16 +: 16] = first[(4+k)*16 +: 16];
      end
   end

   // Byte lanes.
   always_comb begin
      logic [7:0] ab, bb;
      logic [8:0] sb;
      eq_b    = '0;
      addus_b = '0;
      subus_b = '0;
      ilv_b   = '0;
      for (int i = 0; i < 16; i++) begin
         ab = first[i*8 +: 8];
         bb = second[i*8 +: 8];
         sb = {1'b0, ab} + {1'b0, bb};
         eq_b[i*8 +: 8]    = {8{ab == bb}};
         addus_b[i*8 +: 8] = sb[8] ? {8{1'b1}} : sb[7:0];
         subus_b[i*8 +: 8] = (ab >= bb) ? (ab - bb) : 8'd0;
      end
      for (int k = 0; k < 8; k++) begin
         ilv_b[(2*k)*8 +: 8]   = second[(8+k)*8 +: 8];
         ilv_b[(2*k+1)*8 +: 8] = first[(8+k)*8 +: 8];
      end
   end

   always_comb begin
      result = '0;
      status = ST_DONE;
      unique case (opcode)
         OP_ABS_W:    result = abs_w;
         OP_CEQ_W:    result = eq_w;
         OP_MIN_W:    result = min_w;
         OP_SUBADD_H: result = mix_h;
         OP_ABS_H:    result = abs_h;
         OP_CEQ_H:    result = eq_h;
         OP_MIN_H:    result = min_h;
         OP_CEQ_B:    result = eq_b;
         OP_ADDUS_W:  result = addus_w;
         OP_SUBUS_W:  result = subus_w;
         OP_EXTUP_W:  result = ilv_w;
         OP_ADDUS_H:  result = addus_h;
         OP_SUBUS_H:  result = subus_h;
         OP_EXTUP_H:  result = ilv_h;
         OP_ADDUS_B:  result = addus_b;
         OP_SUBUS_B:  result = subus_b;
         OP_EXTUP_B:  result = ilv_b;
         OP_FUNNEL:   status = ST_FUNNEL;
         default:     status = ST_RESERVED;
      endcase
   end

endmodule

// ----- hw/rtl/psalu_checker.sv -----
// ----------------------------------------------------------------------------
// psalu_checker
// Port-level checks for the packed SIMD ALU, bound to the top level.
// ----------------------------------------------------------------------------
module psalu_checker
   import psalu_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [OperandWidth-1:0]   rsp_tdata,
   input logic [StatusWidth-1:0]    rsp_tuser
);

   // Nothing is left in flight after a reset cycle.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result beat keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Reserved and funnel codes never carry data.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DONE |-> rsp_tdata == '0)
      else $error("error status with nonzero data");

   // With no result shown and no request beat throughout the antecedent, the block is
   // empty, so no result beat can show up next.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready)
      ##1 !rsp_tvalid && !(req_tvalid && req_tready)
      |=> !rsp_tvalid)
      else $error("result beat without a request");

   // While the result side never stalls, the input side never stalls either.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_tready) && rsp_tready && !$past(reset) |-> req_tready)
      else $error("request stalled with a free result side");

endmodule

bind packed_simd_alu_128 psalu_checker u_checker (.*);
